### hw/rtl/sact_pkg.sv
package sact_pkg;

  localparam int unsigned LINES    = 1024;
  localparam int unsigned WAYS     = 8;
  localparam int unsigned LINE_AW  = $clog2(LINES);
  localparam int unsigned WAY_W    = 3;
  localparam int unsigned WCNT_W   = 4;
  localparam int unsigned TAG_W    = 30;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned SET_W    = 10;
  localparam int unsigned CFG_IW   = 2;
  localparam int unsigned CFG_DW   = 4;

  localparam logic [CFG_IW-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_SET_BITS    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WAYS_IN_USE = 2'd2;
  localparam logic [CFG_IW-1:0] CFG_REPLACE_LRU = 2'd3;

  localparam logic [1:0] KIND_WRITE = 2'd1;

  typedef struct packed {
    logic [1:0]  access_kind;
    logic [31:0] byte_address;
  } sact_req_t;

  typedef struct packed {
    logic             hit;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way_used;
    logic             writeback;
    logic [TAG_W-1:0] victim_tag;
  } sact_rsp_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] fill;
    logic [STAMP_W-1:0] use_st;
  } sact_line_t;

  localparam int unsigned LINE_W = $bits(sact_line_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_WRITE
  } sact_state_e;

endpackage

### hw/rtl/sact_line_ram.sv
module sact_line_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

### hw/rtl/set_assoc_cache_tag_controller.sv
// Each accepted item is handled alone: the read step reads the line memory once per way
// in use (ways_in_use clamped to 1..8), then drain, then the write step writes the
// chosen line and registers the result; the write step waits while an earlier result
// is not yet taken by ready. No new item is accepted until the block is idle again.
// Reset: asynchronous, active low; afterwards a clearing pass sweeps all 1024 lines
// of the line memory, with no item accepted; config writes are taken.
module set_assoc_cache_tag_controller (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sact_pkg::CFG_IW-1:0]        cfg_index_i,
  input  logic [sact_pkg::CFG_DW-1:0]        cfg_wdata_i,
  input  logic                               req_valid_i,
  output logic                               req_ready_o,
  input  sact_pkg::sact_req_t                req_i,
  output logic                               rsp_valid_o,
  input  logic                               rsp_ready_i,
  output sact_pkg::sact_rsp_t                rsp_o
);
  import sact_pkg::*;

  sact_state_e state_q, state_d;

  logic [3:0] cfg_off_q, cfg_sb_q, cfg_ways_q;
  logic       cfg_lru_q;

  logic [LINE_AW-1:0] clr_q;
  logic [STAMP_W-1:0] cnt_q;

  logic               wr_q;
  logic [TAG_W-1:0]   tag_q;
  logic [SET_W-1:0]   set_q;
  logic [LINE_AW-1:0] base_q;
  logic [WCNT_W-1:0]  ways_q;
  logic [WAY_W-1:0]   w_q;
  logic               ev_v_q;
  logic [WAY_W-1:0]   ev_way_q;

  logic               hit_f_q, inv_f_q, best_dirty_q;
  logic [WAY_W-1:0]   hit_way_q, inv_way_q, best_way_q;
  sact_line_t         hit_ent_q;
  logic [STAMP_W-1:0] best_age_q;
  logic [TAG_W-1:0]   best_tag_q;

  logic       rsp_valid_q;
  sact_rsp_t  rsp_q;

  logic               mem_we, mem_re;
  logic [LINE_AW-1:0] mem_waddr, mem_raddr;
  sact_line_t         mem_wdata, mem_rdata;

  logic in_acc, fin;
  logic last_way;

  // Geometry at accept, clamped.
  logic [3:0]         off_c, sb_c, ways_c;
  logic [4:0]         tsh_c;
  logic [31:0]        sh_set, sh_tag;
  logic [SET_W-1:0]   set_mask, set_c;
  logic [13:0]        base_c;

  always_comb begin
    off_c    = (cfg_off_q < 4'd2) ? 4'd2 : ((cfg_off_q > 4'd12) ? 4'd12 : cfg_off_q);
    sb_c     = (cfg_sb_q > 4'd10) ? 4'd10 : cfg_sb_q;
    ways_c   = (cfg_ways_q == 4'd0) ? 4'd1 :
               ((cfg_ways_q > WCNT_W'(WAYS)) ? WCNT_W'(WAYS) : cfg_ways_q);
    tsh_c    = {1'b0, off_c} + {1'b0, sb_c};
    sh_set   = req_i.byte_address >> off_c;
    sh_tag   = req_i.byte_address >> tsh_c;
    set_mask = SET_W'((11'd1 << sb_c) - 11'd1);
    set_c    = sh_set[SET_W-1:0] & set_mask;
    base_c   = 14'(set_c * ways_c);
  end

  assign in_acc   = req_valid_i && req_ready_o;
  assign last_way = (w_q == 3'(ways_q - 4'd1));
  assign fin      = (state_q == ST_WRITE) && (!rsp_valid_q || rsp_ready_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == LINE_AW'(LINES - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (req_valid_i) state_d = ST_READ;
      ST_READ:  if (last_way) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_WRITE;
      ST_WRITE: if (fin) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Decision for the write back of the chosen line.
  logic [WAY_W-1:0] fin_way;
  logic             fin_wb;
  always_comb begin
    if (hit_f_q) begin
      fin_way = hit_way_q;
    end else if (inv_f_q) begin
      fin_way = inv_way_q;
    end else begin
      fin_way = best_way_q;
    end
    fin_wb = !hit_f_q && !inv_f_q && best_dirty_q;
  end

  // Outputs of the sequencer.
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    mem_re      = (state_q == ST_READ);
    mem_raddr   = base_q + LINE_AW'(w_q);
    mem_we      = 1'b0;
    mem_waddr   = base_q + LINE_AW'(fin_way);
    mem_wdata   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_WRITE: begin
        mem_we = fin;
        if (hit_f_q) begin
          mem_wdata        = hit_ent_q;
          mem_wdata.dirty  = hit_ent_q.dirty | wr_q;
          mem_wdata.use_st = cnt_q;
        end else begin
          mem_wdata.valid  = 1'b1;
          mem_wdata.dirty  = wr_q;
          mem_wdata.tag    = tag_q;
          mem_wdata.fill   = cnt_q;
          mem_wdata.use_st = cnt_q;
        end
      end
      default: ;
    endcase
  end

  sact_line_ram #(
    .DEPTH(LINES),
    .WIDTH(LINE_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      cnt_q      <= '0;
      cfg_off_q  <= 4'd4;
      cfg_sb_q   <= 4'd6;
      cfg_ways_q <= 4'd4;
      cfg_lru_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
      ev_v_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + LINE_AW'(1);
      if (in_acc) cnt_q <= cnt_q + STAMP_W'(1);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_OFFSET_BITS: cfg_off_q  <= cfg_wdata_i;
          CFG_SET_BITS:    cfg_sb_q   <= cfg_wdata_i;
          CFG_WAYS_IN_USE: cfg_ways_q <= cfg_wdata_i;
          CFG_REPLACE_LRU: cfg_lru_q  <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (fin) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      ev_v_q <= (state_q == ST_READ);
    end
  end

  // Per-way evaluation of the word read in the cycle before.
  logic [STAMP_W-1:0] age;
  assign age = cnt_q - (cfg_lru_q ? mem_rdata.use_st : mem_rdata.fill);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wr_q    <= (req_i.access_kind == KIND_WRITE);
      tag_q   <= sh_tag[TAG_W-1:0];
      set_q   <= set_c;
      base_q  <= base_c[LINE_AW-1:0];
      ways_q  <= ways_c;
      w_q     <= '0;
      hit_f_q <= 1'b0;
      inv_f_q <= 1'b0;
    end else if (state_q == ST_READ) begin
      w_q <= w_q + WAY_W'(1);
    end
    if (state_q == ST_READ) ev_way_q <= w_q;
    if (ev_v_q) begin
      if (mem_rdata.valid && mem_rdata.tag == tag_q && !hit_f_q) begin
        hit_f_q   <= 1'b1;
        hit_way_q <= ev_way_q;
        hit_ent_q <= mem_rdata;
      end
      if (!mem_rdata.valid && !inv_f_q) begin
        inv_f_q   <= 1'b1;
        inv_way_q <= ev_way_q;
      end
      if (ev_way_q == '0 || age > best_age_q) begin
        best_age_q   <= age;
        best_way_q   <= ev_way_q;
        best_dirty_q <= mem_rdata.valid && mem_rdata.dirty;
        best_tag_q   <= mem_rdata.tag;
      end
    end
    if (fin) begin
      rsp_q.hit        <= hit_f_q;
      rsp_q.set_index  <= set_q;
      rsp_q.way_used   <= fin_way;
      rsp_q.writeback  <= fin_wb;
      rsp_q.victim_tag <= fin_wb ? best_tag_q : '0;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !req_ready_o)
    else $error("item accepted during clearing pass");
  a_rsp_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q == ST_WRITE))
    else $error("result raised outside the write step");
  a_wb_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(rsp_q.hit && rsp_q.writeback))
    else $error("writeback flagged on a hit");
  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
    else $error("line memory written outside clear or write step");
endmodule

### sim/sact_checker.sv
`timescale 1ns / 1ps

module sact_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sact_pkg::CFG_IW-1:0] cfg_index_i,
  input  logic [sact_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                        req_valid_i,
  input  logic                        req_ready_i,
  input  sact_pkg::sact_req_t         req_i,
  input  logic                        rsp_valid_i,
  input  logic                        rsp_ready_i,
  input  sact_pkg::sact_rsp_t         rsp_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import sact_pkg::*;

  logic               ln_valid [LINES];
  logic               ln_dirty [LINES];
  logic [TAG_W-1:0]   ln_tag   [LINES];
  logic [STAMP_W-1:0] ln_fill  [LINES];
  logic [STAMP_W-1:0] ln_use   [LINES];
  logic [STAMP_W-1:0] access_cnt;
  logic [3:0]         off_reg, sets_reg, ways_reg;
  logic               lru_reg;
  sact_rsp_t          lookup_q[$];

  assign pending_o = lookup_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  function automatic int line_of(int s, int w, int nw);
    return (s * nw + w) % LINES;
  endfunction

  task automatic cache_lookup(input sact_req_t rq);
    int off, sb, nw, s, w, ln, way;
    logic [31:0] tg, age, best;
    logic found, wr;
    sact_rsp_t r;
    off = off_reg < 2 ? 2 : (off_reg > 12 ? 12 : off_reg);
    sb = sets_reg > 10 ? 10 : sets_reg;
    nw = ways_reg == 0 ? 1 : (ways_reg > WAYS ? WAYS : ways_reg);
    wr = rq.access_kind == KIND_WRITE;
    s = (rq.byte_address >> off) & ((32'd1 << sb) - 1);
    tg = (rq.byte_address >> (off + sb)) & 32'h3FFF_FFFF;
    access_cnt = access_cnt + 1;
    r = '0;
    r.set_index = SET_W'(s);
    found = 0;
    way = 0;
    for (w = 0; w < nw && !found; w++) begin
      ln = line_of(s, w, nw);
      if (ln_valid[ln] && ln_tag[ln] == tg[TAG_W-1:0]) begin
        found = 1;
        way = w;
      end
    end
    if (found) begin
      ln = line_of(s, way, nw);
      r.hit = 1;
      ln_use[ln] = access_cnt;
      if (wr) ln_dirty[ln] = 1;
    end else begin
      for (w = 0; w < nw && !found; w++) begin
        ln = line_of(s, w, nw);
        if (!ln_valid[ln]) begin
          found = 1;
          way = w;
        end
      end
      if (!found) begin
        best = 0;
        for (w = 0; w < nw; w++) begin
          ln = line_of(s, w, nw);
          age = access_cnt - (lru_reg ? ln_use[ln] : ln_fill[ln]);
          if (w == 0 || age > best) begin
            best = age;
            way = w;
          end
        end
        ln = line_of(s, way, nw);
        if (ln_valid[ln] && ln_dirty[ln]) begin
          r.writeback = 1;
          r.victim_tag = ln_tag[ln];
        end
      end
      ln = line_of(s, way, nw);
      ln_valid[ln] = 1;
      ln_tag[ln] = tg[TAG_W-1:0];
      ln_fill[ln] = access_cnt;
      ln_use[ln] = access_cnt;
      ln_dirty[ln] = wr;
    end
    r.way_used = WAY_W'(way);
    lookup_q = {lookup_q, r};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sact_rsp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < LINES; i++) begin
        ln_valid[i] = 0;
        ln_dirty[i] = 0;
        ln_tag[i] = '0;
        ln_fill[i] = '0;
        ln_use[i] = '0;
      end
      access_cnt = '0;
      off_reg = 4;
      sets_reg = 6;
      ways_reg = 4;
      lru_reg = 0;
      lookup_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_OFFSET_BITS: off_reg = cfg_wdata_i;
          CFG_SET_BITS:    sets_reg = cfg_wdata_i;
          CFG_WAYS_IN_USE: ways_reg = cfg_wdata_i;
          CFG_REPLACE_LRU: lru_reg = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (req_valid_i && req_ready_i) cache_lookup(req_i);
      if (rsp_valid_i && rsp_ready_i) begin
        if (lookup_q.size() == 0) begin
          report("unexpected item", 32'(rsp_i.set_index), 32'd0);
        end else begin
          want = lookup_q.pop_front();
          if (rsp_i.hit !== want.hit) report("hit", 32'(rsp_i.hit), 32'(want.hit));
          if (rsp_i.set_index !== want.set_index)
            report("set_index", 32'(rsp_i.set_index), 32'(want.set_index));
          if (rsp_i.way_used !== want.way_used)
            report("way_used", 32'(rsp_i.way_used), 32'(want.way_used));
          if (rsp_i.writeback !== want.writeback)
            report("writeback", 32'(rsp_i.writeback), 32'(want.writeback));
          if (rsp_i.victim_tag !== want.victim_tag)
            report("victim_tag", 32'(rsp_i.victim_tag), 32'(want.victim_tag));
        end
      end
    end
  end

endmodule

### sim/tb_set_assoc_cache_tag_controller.sv
`timescale 1ns / 1ps

module tb_set_assoc_cache_tag_controller;
  import sact_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_we_i = 0;
  logic [CFG_IW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_wdata_i = '0;
  logic        req_valid_i = 0;
  logic        req_ready_o;
  sact_req_t   req_i = '0;
  logic        rsp_valid_o;
  logic        rsp_ready_i = 0;
  sact_rsp_t   rsp_o;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          calm;
  logic [31:0] tag_pool[8];

  always #10 clk_i = ~clk_i;

  set_assoc_cache_tag_controller dut (.*);

  sact_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .req_valid_i, .req_ready_i(req_ready_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .rsp_i(rsp_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: no accepted item and no taken result for too long ends the run.
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    rsp_ready_i <= calm ? 1'b1 : ($urandom_range(99) >= 32);
  end

  // Valid stays high into the next item unless an idle cycle drops it.
  task automatic send_access(input logic [1:0] kind, input logic [31:0] addr);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        req_valid_i <= 0;
        @(posedge clk_i);
      end
    end
    req_valid_i <= 1;
    req_i <= '{access_kind: kind, byte_address: addr};
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  task automatic wait_drain();
    req_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [3:0] val);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [3:0] o, input logic [3:0] s,
                              input logic [3:0] w, input logic l);
    write_reg(CFG_OFFSET_BITS, o);
    write_reg(CFG_SET_BITS, s);
    write_reg(CFG_WAYS_IN_USE, w);
    write_reg(CFG_REPLACE_LRU, {3'b000, l});
    cfg_we_i <= 0;
  endtask

  // Mostly reuse a small pool of tags within a few sets to force hits and evictions.
  task automatic random_burst(input int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 80) begin
        a = tag_pool[$urandom_range(7)] ^ ($urandom_range(3) << 6) ^ $urandom_range(15);
      end else begin
        a = $urandom;
      end
      send_access(2'($urandom_range(3)), a);
    end
  endtask

  initial begin
    calm = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int i = 0; i < 8; i++) tag_pool[i] = $urandom & 32'hFFFF_F000;
    // directed: extremes of address and every kind
    send_access(2'd0, 32'h0000_0000);
    send_access(2'd1, 32'hFFFF_FFFF);
    send_access(2'd2, 32'hFFFF_FFFF);
    send_access(2'd3, 32'h0000_0000);
    send_access(2'd1, 32'hAAAA_AAAA);
    send_access(2'd0, 32'h5555_5555);
    // fill one set past its ways with dirty lines, then evict
    for (int i = 0; i < 6; i++) send_access(2'd1, i << 10);
    send_access(2'd0, 32'h0000_0400);
    for (int i = 6; i < 9; i++) send_access(2'd0, i << 10);
    wait_drain();
    // out-of-range settings: clamped to 1024 sets of 8 ways with LRU, then to one way in one set
    set_geometry(4'd0, 4'd15, 4'd15, 1'b1);
    send_access(2'd1, 32'h1234_5678);
    send_access(2'd1, 32'h8765_4321);
    wait_drain();
    set_geometry(4'd15, 4'd0, 4'd0, 1'b0);
    send_access(2'd1, 32'h0000_1000);
    send_access(2'd1, 32'h0000_2000);
    send_access(2'd0, 32'h0000_1000);
    wait_drain();
    // random phases across geometries; the first runs without idling
    for (int p = 0; p < 12; p++) begin
      calm = (p == 0);
      case (p % 4)
        0: set_geometry(4'd4, 4'd2, 4'd4, 1'b1);
        1: set_geometry(4'd2, 4'd0, 4'd8, 1'b0);
        2: set_geometry(4'($urandom_range(15)), 4'($urandom_range(15)),
                        4'($urandom_range(15)), 1'($urandom_range(1)));
        default: set_geometry(4'd12, 4'd10, 4'd2, 1'b1);
      endcase
      random_burst(118);
      wait_drain();
    end
    calm = 0;
    if (fail_count == 0 && pending == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
